// ===== sv/iulc_pkg.sv =====
// Package for the IPv6 upper-layer checksum unit: byte offsets, register reset,
// the staged item type and the end-around-carry adder. No dependencies.
`default_nettype none

package iulc_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [PosW-1:0] PosLenHi    = 17'd4;
  localparam logic [PosW-1:0] PosLenLo    = 17'd5;
  localparam logic [PosW-1:0] PosAddrFirst = 17'd8;
  localparam logic [PosW-1:0] PosHeaderEnd = 17'd40;
  localparam logic [PosW-1:0] PosCsumHi   = 17'd42;
  localparam logic [PosW-1:0] PosCsumLo   = 17'd43;
  localparam logic [PosW-1:0] PosMax      = 17'h1ffff;

  localparam logic [7:0] NextHeaderReset = 8'd58;

  // One staged input byte with its frame marker.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } iulc_item_t;

  // Ones'-complement add of two 16-bit words with the carry folded back in.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/iulc_in_stage.sv =====
// Input register of the IPv6 upper-layer checksum unit.
// Holds one received byte until the checksum core takes it. Uses iulc_pkg.
`default_nettype none

module iulc_in_stage import iulc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_data_i,
  input  wire logic       in_last_i,
  input  wire logic       take_i,
  output iulc_item_t      item_o
);

  logic       valid_q, valid_d;
  logic       last_q;
  logic [7:0] data_q;

  // The register is free when empty or when the core consumes it this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded on every accepted transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
      last_q <= in_last_i;
    end
  end

  assign item_o = '{valid: valid_q, last: last_q, data: data_q};

endmodule

`default_nettype wire

// ===== sv/iulc_core.sv =====
// Checksum core of the IPv6 upper-layer checksum unit: per-packet state,
// at most one ones'-complement add per byte and the result register. Uses iulc_pkg.
`default_nettype none

module iulc_core import iulc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire iulc_item_t  item_i,
  input  wire logic [7:0]  next_header_i,
  output logic             take_o,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [15:0]      res_checksum_o,
  output logic             res_short_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      held_q, held_d;
  logic            res_valid_q, res_valid_d;
  logic [15:0]     res_sum_q;
  logic            res_short_q;

  logic [PosW-1:0] end_pos, end_m1;
  logic            in_region;
  logic [7:0]      val;
  logic            do_add;
  logic [15:0]     add_a, add_b, add_sum;
  logic [15:0]     sum_new;

  // A byte is taken unless it ends a packet and the result slot stays full.
  assign take_o = item_i.valid && (!item_i.last || !res_valid_q || res_ready_i);

  // Payload length is captured from bytes four and five.
  always_comb begin
    len_d = len_q;
    if (pos_q == PosLenHi) begin
      len_d = {item_i.data, 8'h00};
    end else if (pos_q == PosLenLo) begin
      len_d = {len_q[15:8], item_i.data};
    end
  end

  assign end_pos   = PosHeaderEnd + {1'b0, len_d};
  assign end_m1    = end_pos - 17'd1;
  assign in_region = (pos_q >= PosAddrFirst) && (pos_q < end_pos);
  assign val       = (pos_q == PosCsumHi || pos_q == PosCsumLo) ? 8'h00 : item_i.data;

  // One shared adder: the seed at byte five, otherwise a completed word or a zero-padded final byte.
  always_comb begin
    do_add = 1'b0;
    add_a  = sum_q;
    add_b  = {held_q, val};
    if (pos_q == PosLenLo) begin
      do_add = 1'b1;
      add_a  = len_d;
      add_b  = {8'h00, next_header_i};
    end else if (in_region) begin
      if (pos_q[0]) begin
        do_add = 1'b1;
      end else if (pos_q == end_m1 || item_i.last) begin
        do_add = 1'b1;
        add_b  = {val, 8'h00};
      end
    end
  end

  assign add_sum = ones_add(add_a, add_b);
  assign sum_new = do_add ? add_sum : sum_q;

  // Next packet state; the end of a packet returns everything to zero.
  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    held_d = held_q;
    if (take_o) begin
      if (item_i.last) begin
        pos_d  = '0;
        sum_d  = '0;
        held_d = '0;
      end else begin
        sum_d = sum_new;
        if (in_region && !pos_q[0] && !(pos_q == end_m1)) begin
          held_d = val;
        end
        if (pos_q != PosMax) begin
          pos_d = pos_q + 17'd1;
        end
      end
    end
  end

  // Result slot fills at the end of a packet and empties on an output transfer.
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (take_o && item_i.last) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      len_q       <= '0;
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      held_q      <= held_d;
      res_valid_q <= res_valid_d;
      if (take_o) begin
        len_q <= item_i.last ? 16'd0 : len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last) begin
      res_sum_q   <= ~sum_new;
      res_short_q <= (pos_q < end_m1);
    end
  end

  assign res_valid_o    = res_valid_q;
  assign res_checksum_o = res_sum_q;
  assign res_short_o    = res_short_q;

  // A byte that ends a packet always leaves a result behind.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last |=> res_valid_q)
    else $error("end of packet did not load the result register");

  // The end of a packet clears the per-packet state.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last |=> pos_q == '0 && sum_q == '0 && len_q == '0)
    else $error("packet state not cleared after end of packet");

  // Byte offset advances by one per taken byte until it saturates.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && !item_i.last && pos_q != PosMax |=> pos_q == $past(pos_q) + 17'd1)
    else $error("byte offset did not advance");

  // A full result slot that is not drained blocks the next end-of-packet byte.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i && item_i.valid && item_i.last |-> !take_o)
    else $error("pending result would be overwritten");

endmodule

`default_nettype wire

// ===== sv/ipv6_upper_layer_checksum_unit.sv =====
// IPv6 upper-layer checksum unit, top level.
// Instantiates iulc_in_stage and iulc_core and holds the next-header register.
// Uses iulc_pkg.
//
// Usage:
//   The slave stream carries an IPv6 packet one byte per transfer from header
//   byte 0; s_axis_tlast marks its final byte. Every transfer marked last
//   yields one result transfer on the master stream: the 16-bit checksum in
//   m_axis_tdata and a short-packet flag in m_axis_tuser. Other bytes yield
//   nothing.
//   Throughput is one byte per cycle while no last byte waits for the
//   result slot. An accepted last byte passes the input register, then the
//   end-around-carry adder into the result register behind m_axis_tvalid.
//   The next-header register is written on the cfg channel, which is always
//   ready; write it only between packets. It is sampled at byte five.
//   Reset clears all packet state, empties both registers and loads the
//   next-header register with 58.
//   While m_axis_tready is low the result holds; data bytes keep flowing, and
//   only the next last byte waits until the pending result is transferred.
`default_nettype none

module ipv6_upper_layer_checksum_unit import iulc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input byte stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  wire logic        s_axis_tlast,   // end_of_packet
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] checksum
  output logic             m_axis_tuser,   // [0] short_packet
  // Next-header register write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i      // [7:0] next_header_value
);

  iulc_item_t item;
  logic       take;
  logic [7:0] next_header_q;

  // Configuration write: accepted every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_header_q <= NextHeaderReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      next_header_q <= cfg_data_i;
    end
  end

  iulc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .take_i     (take),
    .item_o     (item)
  );

  iulc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .next_header_i  (next_header_q),
    .take_o         (take),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_checksum_o (m_axis_tdata),
    .res_short_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire
